/* sv/mac_keyed_table_with_aging_defines.svh */
// assertion macros for the station table
`ifndef MAC_KEYED_TABLE_WITH_AGING_DEFINES_SVH
`define MAC_KEYED_TABLE_WITH_AGING_DEFINES_SVH

// checked while out of reset
`define MKT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MKT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/mkt_pkg.sv */
package mkt_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned FLAGS_W = 16;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned AGE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SUM_W-1:0]   SUM_MAX       = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [AGE_W-1:0]   AGE_MAX       = '1;
  localparam logic [AGE_W-1:0]   AGE_LIMIT_RST = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT   = 2'd1;

  typedef enum logic [1:0] {
    ACT_OBSERVE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_UPDATED  = 3'd1,
    EV_FILTERED = 3'd2,
    EV_DROPPED  = 3'd3,
    EV_EVICTED  = 3'd4,
    EV_DONE     = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [CHAN_W-1:0]  channel;
    logic [FLAGS_W-1:0] flags;
    logic [LVL_W-1:0]   lvl_last;
    logic [LVL_W-1:0]   lvl_max;
    logic [LVL_W-1:0]   lvl_min;
    logic [SUM_W-1:0]   lvl_sum;
    logic [COUNT_W-1:0] count;
  } info_t;

  typedef struct packed {
    info_t            info;
    logic [AGE_W-1:0] age;
  } slot_rec_t;

endpackage

/* sv/mac_keyed_table_with_aging.sv */
// observe: the scan reads each slot in turn, a valid slot also through ST_EV, up to the match
// or the last slot, then ST_FIN writes back and registers the result; a filtered observe skips the scan
// tick and clear: the same sweep over all slots, then ST_DONE registers the done result; every
// slot goes through the single read port of the slot memory, which sets the rate
// reset clears all valid bits, the registers to flag_filter 0 and age_limit 10, and
// the output valid flag; slot memory contents and the output data registers are not cleared
`include "mac_keyed_table_with_aging_defines.svh"

module mac_keyed_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mkt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mkt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [mkt_pkg::MAC_W-1:0]         station_mac_i,
  input  logic [mkt_pkg::LVL_W-1:0]         signal_level_i,
  input  logic [mkt_pkg::CHAN_W-1:0]        radio_channel_i,
  input  logic [mkt_pkg::FLAGS_W-1:0]       station_flags_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        event_res_o,
  output logic [mkt_pkg::MAC_W-1:0]         entry_mac_o,
  output logic [mkt_pkg::CHAN_W-1:0]        entry_channel_o,
  output logic [mkt_pkg::FLAGS_W-1:0]       entry_flags_o,
  output logic [mkt_pkg::LVL_W-1:0]         level_last_o,
  output logic [mkt_pkg::LVL_W-1:0]         level_max_o,
  output logic [mkt_pkg::LVL_W-1:0]         level_min_o,
  output logic [mkt_pkg::SUM_W-1:0]         level_sum_o,
  output logic [mkt_pkg::COUNT_W-1:0]       sample_count_o,
  output logic                              last_of_run_o
);
  import mkt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [FLAGS_W-1:0] flag_filter_q;
  logic [AGE_W-1:0]   age_limit_q;

  // latched transaction
  action_e            act_q;
  logic [MAC_W-1:0]   in_mac_q;
  logic [LVL_W-1:0]   in_lvl_q;
  logic [CHAN_W-1:0]  in_chan_q;
  logic [FLAGS_W-1:0] in_flags_q;

  logic [IW-1:0]          idx_q, idx_d;
  logic [IW-1:0]          free_idx_q, free_idx_d;
  logic                   hit_q, hit_d;
  logic                   free_found_q, free_found_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  slot_rec_t mem_q [TABLE_DEPTH];
  slot_rec_t rd_q;
  logic      mem_we;
  logic [IW-1:0] mem_waddr;
  slot_rec_t mem_wdata;

  logic   out_valid_q;
  event_e out_ev_q;
  info_t  out_info_q;
  logic   out_last_q;

  logic   out_free;
  logic   out_load;
  event_e out_ev;
  info_t  out_info;
  logic   out_last;

  logic             last_slot;
  logic             filtered;
  logic [AGE_W-1:0] new_age;
  logic             evict;
  logic [SUM_W:0]   sum_ext;
  slot_rec_t        upd_rec;
  slot_rec_t        new_rec;
  info_t            sight_info;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_slot   = (idx_q == IW'(TABLE_DEPTH - 1));
  assign filtered    = |(in_flags_q & flag_filter_q);
  assign new_age     = (rd_q.age == AGE_MAX) ? AGE_MAX : rd_q.age + 1'b1;
  assign evict       = (act_q == ACT_CLEAR) || (new_age > age_limit_q);
  assign sum_ext     = {1'b0, rd_q.info.lvl_sum} + (SUM_W + 1)'(in_lvl_q);

  always_comb begin
    upd_rec               = rd_q;
    upd_rec.info.lvl_last = in_lvl_q;
    if (in_lvl_q > rd_q.info.lvl_max) upd_rec.info.lvl_max = in_lvl_q;
    if (in_lvl_q < rd_q.info.lvl_min) upd_rec.info.lvl_min = in_lvl_q;
    upd_rec.info.lvl_sum  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    if (rd_q.info.count != COUNT_MAX) upd_rec.info.count = rd_q.info.count + 1'b1;
    upd_rec.age           = '0;
  end

  always_comb begin
    new_rec.info.mac      = in_mac_q;
    new_rec.info.channel  = in_chan_q;
    new_rec.info.flags    = in_flags_q;
    new_rec.info.lvl_last = in_lvl_q;
    new_rec.info.lvl_max  = in_lvl_q;
    new_rec.info.lvl_min  = in_lvl_q;
    new_rec.info.lvl_sum  = SUM_W'(in_lvl_q);
    new_rec.info.count    = COUNT_W'(1);
    new_rec.age           = '0;
    sight_info            = '0;
    sight_info.mac        = in_mac_q;
    sight_info.channel    = in_chan_q;
    sight_info.flags      = in_flags_q;
    sight_info.lvl_last   = in_lvl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      flag_filter_q <= '0;
      age_limit_q   <= AGE_LIMIT_RST;
      idx_q         <= '0;
      hit_q         <= 1'b0;
      free_found_q  <= 1'b0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FLAG_FILTER: flag_filter_q <= cfg_data_i;
          CFG_AGE_LIMIT:   age_limit_q   <= cfg_data_i[AGE_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    if (in_valid_i && !in_stall_o) begin
      act_q      <= action_e'(action_i);
      in_mac_q   <= station_mac_i;
      in_lvl_q   <= signal_level_i;
      in_chan_q  <= radio_channel_i;
      in_flags_q <= station_flags_i;
    end
    if (out_load) begin
      out_ev_q   <= out_ev;
      out_info_q <= out_info;
      out_last_q <= out_last;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    valid_d      = valid_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_q;
    out_load     = 1'b0;
    out_ev       = EV_DONE;
    out_info     = '0;
    out_last     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d        = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          case (action_e'(action_i))
            ACT_OBSERVE: begin
              state_d = (|(station_flags_i & flag_filter_q)) ? ST_FIN : ST_RD;
            end
            ACT_TICK, ACT_CLEAR: state_d = ST_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_RD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_EV;
        end else begin
          if (act_q == ACT_OBSERVE && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (last_slot) begin
            state_d = (act_q == ACT_OBSERVE) ? ST_FIN : ST_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_EV: begin
        if (act_q == ACT_OBSERVE) begin
          if (rd_q.info.mac == in_mac_q) begin
            hit_d   = 1'b1;
            state_d = ST_FIN;
          end else if (last_slot) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end else if (!evict || out_free) begin
          // aging write-back, or eviction reported through the output register
          if (evict) begin
            valid_d[idx_q] = 1'b0;
            out_load       = 1'b1;
            out_ev         = EV_EVICTED;
            out_info       = rd_q.info;
          end else begin
            mem_we        = 1'b1;
            mem_wdata.age = new_age;
          end
          if (last_slot) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          state_d  = ST_IDLE;
          out_load = 1'b1;
          out_last = 1'b1;
          if (filtered) begin
            out_ev   = EV_FILTERED;
            out_info = sight_info;
          end else if (hit_q) begin
            mem_we    = 1'b1;
            mem_wdata = upd_rec;
            out_ev    = EV_UPDATED;
            out_info  = upd_rec.info;
          end else if (free_found_q) begin
            mem_we              = 1'b1;
            mem_waddr           = free_idx_q;
            mem_wdata           = new_rec;
            valid_d[free_idx_q] = 1'b1;
            out_ev              = EV_ADDED;
            out_info            = new_rec.info;
          end else begin
            out_ev   = EV_DROPPED;
            out_info = sight_info;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d  = ST_IDLE;
          out_load = 1'b1;
          out_ev   = EV_DONE;
          out_last = 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_ev_q;
  assign entry_mac_o     = out_info_q.mac;
  assign entry_channel_o = out_info_q.channel;
  assign entry_flags_o   = out_info_q.flags;
  assign level_last_o    = out_info_q.lvl_last;
  assign level_max_o     = out_info_q.lvl_max;
  assign level_min_o     = out_info_q.lvl_min;
  assign level_sum_o     = out_info_q.lvl_sum;
  assign sample_count_o  = out_info_q.count;
  assign last_of_run_o   = out_last_q;

  `MKT_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !out_load, "result overwritten while stalled")
  `MKT_ASSERT(a_eval_valid_only, (state_q == ST_EV) |-> valid_q[idx_q], "evaluating an empty slot")
  `MKT_ASSERT(a_clear_empties, (state_q == ST_DONE && act_q == ACT_CLEAR) |-> (valid_q == '0), "clear left entries behind")
  `MKT_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")

endmodule
